// File: design/via_pkg.sv
// ----------------------------------------------------------------------------
// via_pkg
// Request actions, register numbers and interrupt flag positions of the
// interface adapter register block.
// ----------------------------------------------------------------------------
`default_nettype none

package via_pkg;

    typedef enum logic [2:0] {
        ACT_READ  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_CA1   = 3'd2,
        ACT_CA2   = 3'd3,
        ACT_CB1   = 3'd4,
        ACT_CB2   = 3'd5,
        ACT_RESET = 3'd6
    } action_t;

    localparam logic [3:0] REG_PORT_B    = 4'd0;
    localparam logic [3:0] REG_PORT_A    = 4'd1;
    localparam logic [3:0] REG_DDR_B     = 4'd2;
    localparam logic [3:0] REG_DDR_A     = 4'd3;
    localparam logic [3:0] REG_T1_CNT_LO = 4'd4;
    localparam logic [3:0] REG_T1_CNT_HI = 4'd5;
    localparam logic [3:0] REG_T1_LAT_HI = 4'd7;
    localparam logic [3:0] REG_T2_CNT_LO = 4'd8;
    localparam logic [3:0] REG_T2_CNT_HI = 4'd9;
    localparam logic [3:0] REG_SHIFT     = 4'd10;
    localparam logic [3:0] REG_AUX_CTRL  = 4'd11;
    localparam logic [3:0] REG_PER_CTRL  = 4'd12;
    localparam logic [3:0] REG_INT_FLAG  = 4'd13;
    localparam logic [3:0] REG_INT_EN    = 4'd14;
    localparam logic [3:0] REG_PORT_A_NH = 4'd15;

    localparam int FLAG_CA2   = 0;
    localparam int FLAG_CA1   = 1;
    localparam int FLAG_SHIFT = 2;
    localparam int FLAG_CB2   = 3;
    localparam int FLAG_CB1   = 4;
    localparam int FLAG_T2    = 5;
    localparam int FLAG_T1    = 6;
    localparam int FLAG_IRQ   = 7;

    localparam int LINE_CA1 = 0;
    localparam int LINE_CA2 = 1;
    localparam int LINE_CB1 = 2;
    localparam int LINE_CB2 = 3;

    // Peripheral control bits: edge polarity and output-mode select
    localparam int PCR_CA1_RISE = 0;
    localparam int PCR_CA2_RISE = 1;
    localparam int PCR_CA2_OUT  = 3;
    localparam int PCR_CB1_RISE = 4;
    localparam int PCR_CB2_RISE = 5;
    localparam int PCR_CB2_OUT  = 7;

    // Active edge seen: rising when rise is set, falling otherwise
    function automatic logic edge_hit(input logic old_level, input logic new_level,
                                      input logic rise);
        edge_hit = rise ? (!old_level && new_level) : (old_level && !new_level);
    endfunction

endpackage

`default_nettype wire

// File: design/via_port_interrupt_block_top.sv
// ----------------------------------------------------------------------------
// via_port_interrupt_block_top
// Register block of a two-port interface adapter: port data and direction
// registers, edge-sensed control lines CA1, CA2, CB1, CB2 and the interrupt flag/enable pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per accept: a bus
//   read or write of one of sixteen registers, a new level on one of the
//   control lines CA1, CA2, CB1, CB2, or a soft reset of all registers.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   request: read data (zero unless a bus read), irq, both port drive values
//   and both port data latches, all as seen after the request.
//   An accepted request sits in the input register; the register update
//   and result capture happen together when it advances, which waits while
//   an earlier result is held and not yet taken.
//   Throughput is one request per cycle while results are taken; the
//   input and result registers are separate, so a new request is taken
//   while a result waits. When the receiver stalls, the result holds, the
//   input register fills and in_ready drops only when both are occupied.
//   rst_n clears the register file and both valid flags at once; the reset
//   action does the same for the register file as part of normal request flow.
//   Timer registers read as zero; timer accesses at most clear their flags.
// ----------------------------------------------------------------------------
`default_nettype none

module via_port_interrupt_block_top
    import via_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] action,
    input  wire logic [3:0] reg_select,
    input  wire logic [7:0] write_data,
    input  wire logic       pin_level,
    input  wire logic [7:0] port_a_pins,
    input  wire logic [7:0] port_b_pins,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic            irq,
    output logic [7:0]      port_a_drive,
    output logic [7:0]      port_b_drive,
    output logic [7:0]      port_a_latch,
    output logic [7:0]      port_b_latch
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic [2:0] s1_action_reg;
    logic [3:0] s1_reg_sel_reg;
    logic [7:0] s1_wdata_reg;
    logic       s1_level_reg;
    logic [7:0] s1_pa_reg;
    logic [7:0] s1_pb_reg;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [7:0] dir_a_reg, dir_a_next;
    logic [7:0] out_a_reg, out_a_next;
    logic [7:0] dir_b_reg, dir_b_next;
    logic [7:0] out_b_reg, out_b_next;
    logic [3:0] line_levels_reg, line_levels_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] aux_ctrl_reg, aux_ctrl_next;
    logic [7:0] periph_ctrl_reg, periph_ctrl_next;
    logic [7:0] int_flags_reg, int_flags_next;
    logic [6:0] int_enable_reg, int_enable_next;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    logic [7:0] rdata_reg, rdata_next;
    logic       irq_reg;
    logic [7:0] pa_drive_reg, pb_drive_reg;
    logic [7:0] pa_latch_reg, pb_latch_reg;

    logic s1_advance;
    logic in_fire;

    // Advance the input register whenever the result slot is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // ------------------------------------------------------------------
    // One request: read-modify-write of the register file
    // ------------------------------------------------------------------
    always_comb
    begin
        action_t    act;
        logic [7:0] flags;
        logic [7:0] pa_read;
        logic [7:0] pb_read;

        act     = action_t'(s1_action_reg);
        flags   = int_flags_reg;
        pa_read = (out_a_reg & dir_a_reg) | (s1_pa_reg & ~dir_a_reg);
        pb_read = (out_b_reg & dir_b_reg) | (s1_pb_reg & ~dir_b_reg);

        dir_a_next       = dir_a_reg;
        out_a_next       = out_a_reg;
        dir_b_next       = dir_b_reg;
        out_b_next       = out_b_reg;
        line_levels_next = line_levels_reg;
        shift_byte_next  = shift_byte_reg;
        aux_ctrl_next    = aux_ctrl_reg;
        periph_ctrl_next = periph_ctrl_reg;
        int_enable_next  = int_enable_reg;
        rdata_next       = 8'h00;

        case (act)
            ACT_READ:
            begin
                case (s1_reg_sel_reg)
                    REG_PORT_B:
                    begin
                        flags[FLAG_CB1] = 1'b0;
                        flags[FLAG_CB2] = 1'b0;
                        rdata_next      = pb_read;
                    end
                    REG_PORT_A:
                    begin
                        flags[FLAG_CA1] = 1'b0;
                        flags[FLAG_CA2] = 1'b0;
                        rdata_next      = pa_read;
                    end
                    REG_DDR_B:     rdata_next = dir_b_reg;
                    REG_DDR_A:     rdata_next = dir_a_reg;
                    REG_T1_CNT_LO: flags[FLAG_T1] = 1'b0;
                    REG_T2_CNT_LO: flags[FLAG_T2] = 1'b0;
                    REG_SHIFT:
                    begin
                        flags[FLAG_SHIFT] = 1'b0;
                        rdata_next        = shift_byte_reg;
                    end
                    REG_AUX_CTRL:  rdata_next = aux_ctrl_reg;
                    REG_PER_CTRL:  rdata_next = periph_ctrl_reg;
                    REG_INT_FLAG:  rdata_next = int_flags_reg;
                    REG_INT_EN:    rdata_next = {1'b1, int_enable_reg};
                    REG_PORT_A_NH: rdata_next = pa_read;
                    default:       rdata_next = 8'h00;
                endcase
            end
            ACT_WRITE:
            begin
                case (s1_reg_sel_reg)
                    REG_PORT_B:
                    begin
                        flags[FLAG_CB1] = 1'b0;
                        flags[FLAG_CB2] = 1'b0;
                        out_b_next      = s1_wdata_reg;
                    end
                    REG_PORT_A:
                    begin
                        flags[FLAG_CA1] = 1'b0;
                        flags[FLAG_CA2] = 1'b0;
                        out_a_next      = s1_wdata_reg;
                    end
                    REG_DDR_B:     dir_b_next = s1_wdata_reg;
                    REG_DDR_A:     dir_a_next = s1_wdata_reg;
                    REG_T1_CNT_HI,
                    REG_T1_LAT_HI: flags[FLAG_T1] = 1'b0;
                    REG_T2_CNT_HI: flags[FLAG_T2] = 1'b0;
                    REG_SHIFT:
                    begin
                        flags[FLAG_SHIFT] = 1'b0;
                        shift_byte_next   = s1_wdata_reg;
                    end
                    REG_AUX_CTRL:  aux_ctrl_next = s1_wdata_reg;
                    REG_PER_CTRL:  periph_ctrl_next = s1_wdata_reg;
                    REG_INT_FLAG:  flags[6:0] = flags[6:0] & ~s1_wdata_reg[6:0];
                    REG_INT_EN:
                    begin
                        // Bit 7 picks set or clear for the named enable bits
                        if (s1_wdata_reg[7])
                            int_enable_next = int_enable_reg | s1_wdata_reg[6:0];
                        else
                            int_enable_next = int_enable_reg & ~s1_wdata_reg[6:0];
                    end
                    REG_PORT_A_NH: out_a_next = s1_wdata_reg;
                    default:       rdata_next = 8'h00;
                endcase
            end
            ACT_CA1:
            begin
                if (edge_hit(line_levels_reg[LINE_CA1], s1_level_reg,
                             periph_ctrl_reg[PCR_CA1_RISE]))
                    flags[FLAG_CA1] = 1'b1;
                line_levels_next[LINE_CA1] = s1_level_reg;
            end
            ACT_CA2:
            begin
                // CA2 senses edges only in input mode
                if (!periph_ctrl_reg[PCR_CA2_OUT] &&
                    edge_hit(line_levels_reg[LINE_CA2], s1_level_reg,
                             periph_ctrl_reg[PCR_CA2_RISE]))
                    flags[FLAG_CA2] = 1'b1;
                line_levels_next[LINE_CA2] = s1_level_reg;
            end
            ACT_CB1:
            begin
                if (edge_hit(line_levels_reg[LINE_CB1], s1_level_reg,
                             periph_ctrl_reg[PCR_CB1_RISE]))
                    flags[FLAG_CB1] = 1'b1;
                line_levels_next[LINE_CB1] = s1_level_reg;
            end
            ACT_CB2:
            begin
                if (!periph_ctrl_reg[PCR_CB2_OUT] &&
                    edge_hit(line_levels_reg[LINE_CB2], s1_level_reg,
                             periph_ctrl_reg[PCR_CB2_RISE]))
                    flags[FLAG_CB2] = 1'b1;
                line_levels_next[LINE_CB2] = s1_level_reg;
            end
            ACT_RESET:
            begin
                dir_a_next       = 8'h00;
                out_a_next       = 8'h00;
                dir_b_next       = 8'h00;
                out_b_next       = 8'h00;
                line_levels_next = 4'h0;
                shift_byte_next  = 8'h00;
                aux_ctrl_next    = 8'h00;
                periph_ctrl_next = 8'h00;
                int_enable_next  = 7'h00;
                flags            = 8'h00;
            end
            default:
            begin
                // Unused action code: state untouched, result still reported
                rdata_next = 8'h00;
            end
        endcase

        // Summary bit follows the enabled flags after every request
        int_flags_next = {|(flags[6:0] & int_enable_next), flags[6:0]};
    end

    // ------------------------------------------------------------------
    // Control state and register file
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            dir_a_reg       <= 8'h00;
            out_a_reg       <= 8'h00;
            dir_b_reg       <= 8'h00;
            out_b_reg       <= 8'h00;
            line_levels_reg <= 4'h0;
            shift_byte_reg  <= 8'h00;
            aux_ctrl_reg    <= 8'h00;
            periph_ctrl_reg <= 8'h00;
            int_flags_reg   <= 8'h00;
            int_enable_reg  <= 7'h00;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (s1_advance)
            begin
                dir_a_reg       <= dir_a_next;
                out_a_reg       <= out_a_next;
                dir_b_reg       <= dir_b_next;
                out_b_reg       <= out_b_next;
                line_levels_reg <= line_levels_next;
                shift_byte_reg  <= shift_byte_next;
                aux_ctrl_reg    <= aux_ctrl_next;
                periph_ctrl_reg <= periph_ctrl_next;
                int_flags_reg   <= int_flags_next;
                int_enable_reg  <= int_enable_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: load the input stage on accept, the result on advance
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg  <= action;
            s1_reg_sel_reg <= reg_select;
            s1_wdata_reg   <= write_data;
            s1_level_reg   <= pin_level;
            s1_pa_reg      <= port_a_pins;
            s1_pb_reg      <= port_b_pins;
        end
        if (s1_advance)
        begin
            rdata_reg    <= rdata_next;
            irq_reg      <= int_flags_next[FLAG_IRQ];
            pa_drive_reg <= (out_a_next & dir_a_next) | ~dir_a_next;
            pb_drive_reg <= (out_b_next & dir_b_next) | ~dir_b_next;
            pa_latch_reg <= out_a_next;
            pb_latch_reg <= out_b_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign irq          = irq_reg;
    assign port_a_drive = pa_drive_reg;
    assign port_b_drive = pb_drive_reg;
    assign port_a_latch = pa_latch_reg;
    assign port_b_latch = pb_latch_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_summary_tracks_flags: assert property (@(posedge clk) disable iff (!rst_n)
        int_flags_reg[FLAG_IRQ] == |(int_flags_reg[6:0] & int_enable_reg))
        else $error("interrupt summary bit out of step with flags and enables");

    a_reset_action_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_action_reg == ACT_RESET) |=>
            (int_flags_reg == 8'h00) && (int_enable_reg == 7'h00) &&
            (dir_a_reg == 8'h00) && (dir_b_reg == 8'h00) &&
            (periph_ctrl_reg == 8'h00) && (line_levels_reg == 4'h0))
        else $error("reset action left register state behind");

    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_action_reg != ACT_READ) |=> (read_data == 8'h00))
        else $error("nonzero read data for a request other than a bus read");

    a_drive_covers_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((port_a_drive & port_a_latch) == port_a_latch) &&
                      ((port_b_drive & port_b_latch) == port_b_latch))
        else $error("port drive low where data latch is high");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
